### rtl/fss_pkg.sv
// ----------------------------------------------------------------------------
// fss_pkg: flight safety supervisor shared definitions
// State codes, the condition vector layout and the width constants used by
// the supervisor core and its transition logic.
// ----------------------------------------------------------------------------
package fss_pkg;

	localparam int unsigned CondWidth  = 8;
	localparam int unsigned StateWidth = 4;
	localparam int unsigned DataWidth  = 8;

	typedef logic [StateWidth-1:0] state_t;

	// supervisor state codes
	localparam state_t ST_NOT_INIT       = 4'd0;
	localparam state_t ST_PRE_NOT_PASSED = 4'd1;
	localparam state_t ST_PRE_PASSED     = 4'd2;
	localparam state_t ST_READY          = 4'd3;
	localparam state_t ST_FLYING         = 4'd4;
	localparam state_t ST_LANDED         = 4'd5;
	localparam state_t ST_RESET          = 4'd6;
	localparam state_t ST_WARN_LEVEL_OUT = 4'd7;
	localparam state_t ST_FREE_FALL      = 4'd8;
	localparam state_t ST_LOCKED         = 4'd9;
	localparam state_t ST_CRASHED        = 4'd10;

	// condition vector, bit 0 (armed) in the lowest position
	typedef struct packed {
		logic land_timeout;
		logic crashed;
		logic estop;
		logic wdt_timeout;
		logic wdt_warning;
		logic tumbled;
		logic flying;
		logic armed;
	} cond_t;

endpackage

### rtl/fss_next_state.sv
// ----------------------------------------------------------------------------
// fss_next_state: supervisor transition logic
// Priority-ordered rules per state; the first rule that fires picks the next
// state, otherwise the current state is kept.
// ----------------------------------------------------------------------------
module fss_next_state (
	input  fss_pkg::state_t state,
	input  fss_pkg::cond_t  cond,
	input  logic            tumble_check_enable,
	output fss_pkg::state_t next_state
);

	logic tumble;

	// tumble only counts while checking is enabled
	assign tumble = cond.tumbled & tumble_check_enable;

	// transition rules, highest priority first
	always_comb begin
		next_state = state;
		unique case (state)
			fss_pkg::ST_NOT_INIT: begin
				next_state = fss_pkg::ST_PRE_NOT_PASSED;
			end
			fss_pkg::ST_PRE_NOT_PASSED: begin
				if (cond.estop)
					next_state = fss_pkg::ST_FREE_FALL;
				else if (!tumble)
					next_state = fss_pkg::ST_PRE_PASSED;
			end
			fss_pkg::ST_PRE_PASSED: begin
				if (cond.estop)
					next_state = fss_pkg::ST_FREE_FALL;
				else if (tumble)
					next_state = fss_pkg::ST_PRE_NOT_PASSED;
				else if (cond.armed)
					next_state = fss_pkg::ST_READY;
			end
			fss_pkg::ST_READY: begin
				if (cond.estop)
					next_state = fss_pkg::ST_FREE_FALL;
				else if (tumble || !cond.armed)
					next_state = fss_pkg::ST_PRE_NOT_PASSED;
				else if (cond.flying)
					next_state = fss_pkg::ST_FLYING;
			end
			fss_pkg::ST_FLYING: begin
				if (cond.wdt_timeout || cond.estop || !cond.armed)
					next_state = fss_pkg::ST_FREE_FALL;
				else if (tumble)
					next_state = fss_pkg::ST_CRASHED;
				else if (cond.wdt_warning)
					next_state = fss_pkg::ST_WARN_LEVEL_OUT;
				else if (!cond.flying)
					next_state = fss_pkg::ST_LANDED;
			end
			fss_pkg::ST_LANDED: begin
				if (cond.land_timeout)
					next_state = fss_pkg::ST_RESET;
				else if (cond.flying)
					next_state = fss_pkg::ST_FLYING;
			end
			fss_pkg::ST_RESET: begin
				next_state = fss_pkg::ST_PRE_NOT_PASSED;
			end
			fss_pkg::ST_WARN_LEVEL_OUT: begin
				if (cond.wdt_timeout || tumble || cond.estop || !cond.armed)
					next_state = fss_pkg::ST_FREE_FALL;
				else if (!cond.wdt_warning)
					next_state = fss_pkg::ST_FLYING;
			end
			fss_pkg::ST_FREE_FALL: begin
				next_state = fss_pkg::ST_LOCKED;
			end
			fss_pkg::ST_LOCKED: begin
				next_state = state;
			end
			fss_pkg::ST_CRASHED: begin
				// raw tumbled bit here, regardless of the enable
				if (!cond.crashed && !cond.tumbled)
					next_state = fss_pkg::ST_PRE_NOT_PASSED;
				else if (cond.estop)
					next_state = fss_pkg::ST_LOCKED;
			end
			default: begin
				next_state = state;
			end
		endcase
	end

endmodule

### rtl/flight_safety_supervisor_fsm_core.sv
// ----------------------------------------------------------------------------
// flight_safety_supervisor_fsm_core: flight safety supervisor
// Takes one condition vector per transfer and returns the next supervisor
// state together with a flag that marks a change of state.
// ----------------------------------------------------------------------------
// A result is offered once its input has passed the input register, then
// the result register; a stall on the result stream holds both.
// Throughput: one item per cycle while the result stream is not stalled;
// the state register feeds back through the transition logic.
// Reset: state goes to not initialized, tumble checking enabled, both
// stages empty.
module flight_safety_supervisor_fsm_core (
	input  logic clk,
	input  logic arst_n,
	// configuration
	input  logic cfg_wr_en,
	input  logic cfg_wr_data,
	// input stream
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [fss_pkg::DataWidth-1:0] s_tdata,  // [7:0] condition_bits
	// result stream
	output logic m_tvalid,
	input  logic m_tready,
	output logic [fss_pkg::DataWidth-1:0] m_tdata   // [3:0] next_state, [4] state_changed
);

	logic            tumble_en_q;
	fss_pkg::state_t state_q;

	logic            valid_s1;
	fss_pkg::cond_t  cond_s1;

	logic            out_valid_q;
	fss_pkg::state_t out_state_q;
	logic            out_changed_q;

	fss_pkg::state_t next_state;
	logic            advance;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tumble_en_q <= 1'b1;
		end else if (cfg_wr_en) begin
			tumble_en_q <= cfg_wr_data;
		end
	end

	// handshake: s1 moves on whenever the result register is free or drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cond_s1 <= fss_pkg::cond_t'(s_tdata);
		end
	end

	// transition logic
	fss_next_state u_next (
		.state               (state_q),
		.cond                (cond_s1),
		.tumble_check_enable (tumble_en_q),
		.next_state          (next_state)
	);

	// supervisor state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fss_pkg::ST_NOT_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= next_state;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_state_q   <= next_state;
			out_changed_q <= (next_state != state_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(fss_pkg::DataWidth - fss_pkg::StateWidth - 1){1'b0}},
		out_changed_q, out_state_q};

	// checks
	a_out_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[fss_pkg::StateWidth-1:0] == state_q))
		else $error("offered result differs from supervisor state");

	a_locked_absorbs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fss_pkg::ST_LOCKED) |=> (state_q == fss_pkg::ST_LOCKED))
		else $error("left locked state");

	a_free_fall_locks: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (state_q == fss_pkg::ST_FREE_FALL)) |=>
		(state_q == fss_pkg::ST_LOCKED))
		else $error("free fall not followed by locked");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(cond_s1)))
		else $error("pending input overwritten");

	a_state_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("state moved without a transfer");

endmodule
